// ===== rtl/cphu_pkg.sv =====
// Package: shared constants, types and the arctangent table for the phase unwrapper.
package cphu_pkg;

   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int MAX_SWEEP_DEF     = 1024;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int FIELD_W       = 16;
   localparam int RAW_BITS      = 32;
   localparam int PRESCALE_BITS = 24;
   localparam int ATAN_LEN      = 24;
   localparam int ATAN_W        = 22;
   localparam int Z_W           = 27;
   localparam int PHASE_W       = 17;
   localparam int ACC_W         = 27;

   localparam int HALF_TURN_Q8 = 46080;
   localparam int FULL_TURN_Q8 = 92160;
   localparam int HALF_TURN_Z  = 11796480;
   localparam int ROUND_HALF   = 128;
   localparam int ROUND_SHIFT  = 8;
   localparam int OUT_LIMIT    = 67108863;

   typedef logic signed [FIELD_W-1:0] sample_type;
   typedef logic signed [PHASE_W-1:0] phase_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   // atan(2^-k) in degrees * 2^16
   function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:       v = 22'd2949120;
         1:       v = 22'd1740967;
         2:       v = 22'd919879;
         3:       v = 22'd466945;
         4:       v = 22'd234379;
         5:       v = 22'd117304;
         6:       v = 22'd58666;
         7:       v = 22'd29335;
         8:       v = 22'd14668;
         9:       v = 22'd7334;
         10:      v = 22'd3667;
         11:      v = 22'd1833;
         12:      v = 22'd917;
         13:      v = 22'd458;
         14:      v = 22'd229;
         15:      v = 22'd115;
         16:      v = 22'd57;
         17:      v = 22'd29;
         18:      v = 22'd14;
         19:      v = 22'd7;
         20:      v = 22'd4;
         21:      v = 22'd2;
         22:      v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/cphu_if.sv =====
// Interfaces: sample request channel and unwrapped phase response channel.
interface cphu_req_if
   import cphu_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type i_sample;
   sample_type q_sample;
   logic       end_of_sweep;

   modport source (output valid, i_sample, q_sample, end_of_sweep, input ready);
   modport sink   (input valid, i_sample, q_sample, end_of_sweep, output ready);
endinterface

interface cphu_rsp_if
   import cphu_pkg::*;
();
   logic    valid;
   logic    ready;
   acc_type unwrapped_phase;
   logic    sweep_done;

   modport source (output valid, unwrapped_phase, sweep_done, input ready);
   modport sink   (input valid, unwrapped_phase, sweep_done, output ready);
endinterface

// ===== rtl/complex_phase_unwrap.sv =====
// Top level: iterative CORDIC atan2 with sweep phase unwrapping and saturation.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | i_sample, q_sample, end_of_sweep
//   rsp     | out | valid/ready | unwrapped_phase, sweep_done
//
// An item is loaded, rotated min(CORDIC_STAGES,24) times on the shared x/y/z
// adder set, rounded, then unwrapped.
// reset sets the sweep start flag; clears sequencer, previous phase, accumulator.
// req.ready is high only while the sequencer is idle; a result waiting in the
// output register does not block the next item, but the unwrap step holds until
// that register is free.
module complex_phase_unwrap
   import cphu_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int MAX_SWEEP     = MAX_SWEEP_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic        clock,
   input logic        reset,
   cphu_req_if.sink   req,
   cphu_rsp_if.source rsp
);

   localparam int STG = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
   localparam int KW  = $clog2(STG);
   localparam int SW  = SAMPLE_BITS + 3;
   localparam int DW  = SW + PRESCALE_BITS;
   localparam int DIFF_W = PHASE_W + 2;
   localparam int SUM_W  = ACC_W + 1;
   localparam longint BOUND_FULL = longint'(MAX_SWEEP) * longint'(HALF_TURN_Q8);
   localparam int BOUND = (BOUND_FULL > longint'(OUT_LIMIT)) ? OUT_LIMIT : int'(BOUND_FULL);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROT  = 2'd1;
   localparam logic [1:0] ST_RND  = 2'd2;
   localparam logic [1:0] ST_UPD  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [KW-1:0]         k_ff, k_in;
   logic signed [DW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic                  special_ff, special_in;
   logic                  left_ff, left_in;
   logic                  last_ff, last_in;
   phase_type             cur_ff, cur_in;
   logic                  first_ff, first_in;
   phase_type             prev_ff, prev_in;
   acc_type               acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   acc_type               rsp_phase_ff, rsp_phase_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [RAW_BITS-1:0]          i_raw, q_raw;
   logic signed [SAMPLE_BITS-1:0] i_sb, q_sb;
   logic signed [SW-1:0]         i_ext, q_ext, x0, y0;
   logic signed [Z_W-1:0]        z0;
   logic                         in_left;
   logic                         accept;
   logic                         upd_fire;
   logic signed [DW-1:0]         dx, dy;
   logic signed [Z_W-1:0]        atan_k;
   logic                         y_pos;
   logic signed [Z_W-1:0]        z_rnd, z_sh, z_clamp;
   logic signed [DIFF_W-1:0]     diff, step;
   logic signed [SUM_W-1:0]      sum;
   acc_type                      acc_clamp;

   assign accept   = req.valid && req.ready;
   assign upd_fire = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp.ready);

   // sample conversion and half-plane fold
   always_comb begin
      i_raw   = {{(RAW_BITS - FIELD_W){1'b0}}, req.i_sample};
      q_raw   = {{(RAW_BITS - FIELD_W){1'b0}}, req.q_sample};
      i_sb    = i_raw[SAMPLE_BITS-1:0];
      q_sb    = q_raw[SAMPLE_BITS-1:0];
      i_ext   = SW'(i_sb);
      q_ext   = SW'(q_sb);
      in_left = i_ext[SW-1];
      x0      = in_left ? -i_ext : i_ext;
      y0      = in_left ? -q_ext : q_ext;
      if (!in_left) begin
         z0 = '0;
      end else if (!q_ext[SW-1]) begin
         z0 = Z_W'(HALF_TURN_Z);
      end else begin
         z0 = Z_W'(-HALF_TURN_Z);
      end
   end

   // shared rotation unit
   always_comb begin
      dx     = y_ff >>> k_ff;
      dy     = x_ff >>> k_ff;
      atan_k = Z_W'(atan_q16(int'(k_ff)));
      y_pos  = !y_ff[DW-1] && (|y_ff);
   end

   // round to Q8 and clamp
   always_comb begin
      z_rnd = z_ff + Z_W'(ROUND_HALF);
      z_sh  = z_rnd >>> ROUND_SHIFT;
      priority if (z_sh > Z_W'(HALF_TURN_Q8)) begin
         z_clamp = Z_W'(HALF_TURN_Q8);
      end else if (z_sh < Z_W'(-HALF_TURN_Q8)) begin
         z_clamp = Z_W'(-HALF_TURN_Q8);
      end else begin
         z_clamp = z_sh;
      end
   end

   // wrap step into [-180,180) and accumulate with saturation
   always_comb begin
      diff = DIFF_W'(cur_ff) - DIFF_W'(prev_ff);
      priority if (diff >= DIFF_W'(HALF_TURN_Q8)) begin
         step = diff - DIFF_W'(FULL_TURN_Q8);
      end else if (diff < DIFF_W'(-HALF_TURN_Q8)) begin
         step = diff + DIFF_W'(FULL_TURN_Q8);
      end else begin
         step = diff;
      end
      sum = first_ff ? SUM_W'(cur_ff) : (SUM_W'(acc_ff) + SUM_W'(step));
      priority if (sum > SUM_W'(BOUND)) begin
         acc_clamp = ACC_W'(BOUND);
      end else if (sum < SUM_W'(-BOUND)) begin
         acc_clamp = ACC_W'(-BOUND);
      end else begin
         acc_clamp = sum[ACC_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      special_in   = special_ff;
      left_in      = left_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_phase_in = rsp_phase_ff;
      rsp_done_in  = rsp_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_ROT;
               k_in       = '0;
               x_in       = $signed({x0, {PRESCALE_BITS{1'b0}}});
               y_in       = $signed({y0, {PRESCALE_BITS{1'b0}}});
               z_in       = z0;
               special_in = (q_ext == '0);
               left_in    = in_left;
               last_in    = req.end_of_sweep;
            end
         end
         ST_ROT: begin
            if (y_pos) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_k;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_k;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == KW'(STG - 1)) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            // real axis: exact 0, or +180 on the negative side
            if (special_ff) begin
               cur_in = left_ff ? PHASE_W'(HALF_TURN_Q8) : '0;
            end else begin
               cur_in = z_clamp[PHASE_W-1:0];
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_fire) begin
               acc_in       = acc_clamp;
               prev_in      = cur_ff;
               first_in     = last_ff;
               rsp_valid_in = 1'b1;
               rsp_phase_in = acc_clamp;
               rsp_done_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         prev_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      special_ff   <= special_in;
      left_ff      <= left_in;
      last_ff      <= last_in;
      cur_ff       <= cur_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.unwrapped_phase = rsp_phase_ff;
   assign rsp.sweep_done      = rsp_done_ff;

`ifndef ASSERT_OFF
   a_accept_starts_rot: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ROT))
      else $error("accepted item did not start rotation");

   a_result_from_upd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPD))
      else $error("result appeared without an unwrap step");

   a_result_in_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_phase_ff <= ACC_W'(BOUND)) && (rsp_phase_ff >= ACC_W'(-BOUND))))
      else $error("unwrapped phase beyond saturation bound");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> ((cur_ff <= PHASE_W'(HALF_TURN_Q8))
                                && (cur_ff >= PHASE_W'(-HALF_TURN_Q8))))
      else $error("wrapped phase out of half-turn range");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for complex_phase_unwrap: directed and random sweeps checked against a local predictor.
module tb;
   import cphu_pkg::*;

   localparam int IDLE_PCT       = 27;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint PRESCALE   = 64'sd1 <<< PRESCALE_BITS;
   localparam real    PI         = 3.14159265358979;

   typedef struct {
      acc_type phase;
      logic    done;
   } unwrap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cphu_req_if req_ch ();
   cphu_rsp_if rsp_ch ();

   complex_phase_unwrap u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // arctangent of 2^-k, degrees * 2^16
   longint arctan_q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   unwrap_result_type pending_phases [$];

   // predictor state
   logic   sweep_open_next = 1'b1;
   longint last_phase      = 0;
   longint unwrap_total    = 0;

   int  mismatches      = 0;
   int  samples_sent    = 0;
   int  sweeps_closed   = 0;
   int  results_checked = 0;
   int  top_clamps      = 0;
   int  bottom_clamps   = 0;
   int  holds_asked     = 0;
   logic steady         = 1'b0;

   function automatic longint cordic_phase(input sample_type si, input sample_type sq);
      longint x, y, z, dx, dy;
      int     stages;
      stages = (CORDIC_STAGES_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES_DEF;
      if (sq == 0)
         return (si < 0) ? HALF_TURN_Q8 : 0;
      if (si < 0) begin
         x = -longint'(si);
         y = -longint'(sq);
         z = (sq >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      end else begin
         x = longint'(si);
         y = longint'(sq);
         z = 0;
      end
      x = x * PRESCALE;
      y = y * PRESCALE;
      for (int k = 0; k < stages; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + arctan_q16[k];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - arctan_q16[k];
         end
      end
      z = (z + ROUND_HALF) >>> ROUND_SHIFT;
      if (z > HALF_TURN_Q8)
         z = HALF_TURN_Q8;
      if (z < -HALF_TURN_Q8)
         z = -HALF_TURN_Q8;
      return z;
   endfunction

   function automatic void predict_unwrap(input sample_type si, input sample_type sq,
                                          input logic last);
      longint            cur, step, bound;
      unwrap_result_type r;
      cur   = cordic_phase(si, sq);
      bound = longint'(MAX_SWEEP_DEF) * HALF_TURN_Q8;
      if (bound > OUT_LIMIT)
         bound = OUT_LIMIT;
      if (sweep_open_next) begin
         unwrap_total = cur;
      end else begin
         // step wrapped into [-180, 180): exactly +180 goes to -180
         step = cur - last_phase + HALF_TURN_Q8;
         step = step % FULL_TURN_Q8;
         if (step < 0)
            step = step + FULL_TURN_Q8;
         unwrap_total = unwrap_total + step - HALF_TURN_Q8;
      end
      if (unwrap_total > bound) begin
         unwrap_total = bound;
         top_clamps++;
      end
      if (unwrap_total < -bound) begin
         unwrap_total = -bound;
         bottom_clamps++;
      end
      last_phase      = cur;
      sweep_open_next = last;
      r.phase = acc_type'(unwrap_total);
      r.done  = last;
      pending_phases.insert(pending_phases.size(), r);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH result %0d: %s", results_checked, msg);
      mismatches++;
   endtask

   // one item; valid stays high across back-to-back items
   task automatic send_sample(input int si, input int sq, input bit last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.i_sample     <= sample_type'(si);
      req_ch.q_sample     <= sample_type'(sq);
      req_ch.end_of_sweep <= last;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      predict_unwrap(sample_type'(si), sample_type'(sq), last);
      samples_sent++;
      if (last)
         sweeps_closed++;
   endtask

   // result side: random stalls, plus a long hold when asked
   initial begin : result_sink
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : result_check
      unwrap_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_phases.size() == 0) begin
            report_mismatch($sformatf("unexpected result phase %0d done %0b",
                                      rsp_ch.unwrapped_phase, rsp_ch.sweep_done));
         end else begin
            want = pending_phases.pop_front();
            if (rsp_ch.unwrapped_phase !== want.phase)
               report_mismatch($sformatf("unwrapped_phase got %0d expected %0d",
                                         rsp_ch.unwrapped_phase, want.phase));
            if (rsp_ch.sweep_done !== want.done)
               report_mismatch($sformatf("sweep_done got %b expected %b",
                                         rsp_ch.sweep_done, want.done));
         end
         results_checked++;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("complex_phase_unwrap verification failed");
      $finish;
   end

   // zero, both real axes, both imaginary axes, exact +180 step
   task automatic test_axes_and_zero();
      send_sample(0, 0, 1'b0);
      send_sample(100, 0, 1'b0);
      send_sample(-100, 0, 1'b0);
      send_sample(0, 0, 1'b0);
      send_sample(0, 5, 1'b0);
      send_sample(0, -5, 1'b0);
      send_sample(-1, 0, 1'b1);
   endtask

   // field extremes, every quadrant, one-sample sweep
   task automatic test_extremes();
      send_sample(-32768, -32768, 1'b0);
      send_sample(32767, 32767, 1'b0);
      send_sample(-32768, 32767, 1'b0);
      send_sample(32767, -32768, 1'b0);
      send_sample(-32768, 0, 1'b0);
      send_sample(0, -32768, 1'b0);
      send_sample(0, 32767, 1'b0);
      send_sample(32767, 0, 1'b0);
      send_sample(-1, 1, 1'b0);
      send_sample(-1, -1, 1'b0);
      send_sample(1, -1, 1'b0);
      send_sample(-32768, -1, 1'b0);
      send_sample(-32768, 1, 1'b1);
      send_sample(5, 7, 1'b1);
   endtask

   // output held off while the sender keeps offering
   task automatic test_backpressure();
      steady      <= 1'b1;
      holds_asked <= holds_asked + 1;
      for (int n = 0; n < 24; n++)
         send_sample(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                     n == 23);
      steady <= 1'b0;
   endtask

   // steps near +179 degrees run the total into the upper bound
   task automatic test_top_saturation();
      real ang;
      int  mag;
      for (int k = 0; k < 1040; k++) begin
         ang = (real'((longint'(k) * 179) % 360)
                + real'(int'($urandom_range(60)) - 30) / 100.0) * PI / 180.0;
         mag = $urandom_range(32767, 2000);
         send_sample($rtoi(mag * $cos(ang)), $rtoi(mag * $sin(ang)), k == 1039);
      end
   endtask

   // real-axis flips give -180 each step toward the lower bound
   task automatic test_bottom_saturation();
      int mag;
      for (int k = 0; k < 1030; k++) begin
         mag = $urandom_range(32767, 1);
         send_sample((k % 2 == 0) ? mag : -mag, 0, k == 1029);
      end
   endtask

   task automatic test_random_sweeps();
      int si, sq, kind;
      int picks [5] = '{-32768, -1, 0, 1, 32767};
      for (int n = 0; n < 100; n++) begin
         if (n == 40)
            steady <= 1'b1;
         if (n == 70)
            steady <= 1'b0;
         kind = $urandom_range(9);
         if (kind < 6) begin
            si = int'($urandom_range(65535)) - 32768;
            sq = int'($urandom_range(65535)) - 32768;
         end else if (kind < 8) begin
            si = int'($urandom_range(6)) - 3;
            sq = int'($urandom_range(6)) - 3;
         end else begin
            si = picks[$urandom_range(4)];
            sq = picks[$urandom_range(4)];
         end
         send_sample(si, sq, $urandom_range(5) == 0);
      end
   endtask

   initial begin : main
      req_ch.valid        <= 1'b0;
      req_ch.i_sample     <= '0;
      req_ch.q_sample     <= '0;
      req_ch.end_of_sweep <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_axes_and_zero();
      test_extremes();
      test_backpressure();
      test_top_saturation();
      test_bottom_saturation();
      test_random_sweeps();

      req_ch.valid <= 1'b0;
      while (pending_phases.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d samples in %0d closed sweeps, %0d results checked",
               samples_sent, sweeps_closed, results_checked);
      $display("run: upper bound clamped %0d times, lower bound %0d times, one long output hold",
               top_clamps, bottom_clamps);
      if (mismatches == 0 && pending_phases.size() == 0) begin
         $display("complex_phase_unwrap verification clean");
      end else begin
         $display("complex_phase_unwrap verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cphu_pkg.sv
rtl/cphu_if.sv
rtl/complex_phase_unwrap.sv
tb/tb.sv
